// ===== hdl/lmss_pkg.sv =====
`timescale 1ns / 1ps

package lmss_pkg;

  // Pattern store geometry
  localparam int PATTERN_DEPTH = 64;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);

  // Matrix geometry and field widths
  localparam int NUM_COLS   = 8;
  localparam int COL_W      = 3;
  localparam int ROW_W      = 8;
  localparam int OFFS_W     = 6;
  localparam int LOAD_ADR_W = 6;
  localparam int REPS_W     = 8;
  localparam int STEPS_W    = 6;

  // offset + column, wide enough to never wrap before the store modulo
  localparam int SUM_W    = OFFS_W + 1;
  localparam int SUM_SPAN = 1 << SUM_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [REPS_W-1:0]  RST_FRAME_REPEATS = REPS_W'(10);
  localparam logic [STEPS_W-1:0] RST_SCROLL_STEPS  = STEPS_W'(30);
  localparam logic               RST_SCROLL_MODE   = 1'b1;

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;

  // Result queue
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_REPEATS = 2'd0,
    CFG_SCROLL_STEPS  = 2'd1,
    CFG_SCROLL_MODE   = 2'd2
  } cfg_idx_e;

  // One result, row_bits in the lowest bits
  typedef struct packed {
    logic                done_res;
    logic [OFFS_W-1:0]   window_offset;
    logic [NUM_COLS-1:0] col_enable_n;
    logic [ROW_W-1:0]    row_bits;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // Store address wrap, built at elaboration
  typedef logic [ADDR_W-1:0] mod_tbl_t [SUM_SPAN];

  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    for (int i = 0; i < SUM_SPAN; i++) begin
      t[i] = ADDR_W'(i % PATTERN_DEPTH);
    end
    return t;
  endfunction

  localparam mod_tbl_t MOD_TBL = build_mod_tbl();

endpackage

// ===== hdl/lmss_ram.sv =====
`timescale 1ns / 1ps

module lmss_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lmss_col_cell.sv =====
`timescale 1ns / 1ps

// One column slot of the scan ring: holds the token bit, passes it on per tick.
module lmss_col_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic rst_token_i,
  input  logic shift_i,
  input  logic token_i,
  output logic token_o,
  output logic col_n_o
);

  logic token_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= rst_token_i;
    end else if (shift_i) begin
      token_q <= token_i;
    end
  end

  assign token_o = token_q;
  assign col_n_o = ~token_q;

endmodule

// ===== hdl/lmss_out_fifo.sv =====
`timescale 1ns / 1ps

module lmss_out_fifo import lmss_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  res_t                 push_data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output res_t                 data_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  res_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hdl/led_matrix_scroll_scanner_core.sv =====
`timescale 1ns / 1ps

// 8x8 LED matrix column scanner with scrolling window. Each input transaction is
// either a load (tuser = 0: write one pattern byte) or a tick (tuser = 1: light
// the next column) and yields exactly one result transaction. A tick drives one
// column low and shows pattern byte [offset + column]; a load returns rows 0 and
// all columns off. Throughput is one transaction per clock while s_axis_tready is
// high: the pattern store is read in the accept cycle and its registered data
// joins the result in the next cycle. A three-entry result queue absorbs
// downstream stalls; s_axis_tready drops only when three results are queued or
// in flight. The column position lives in a ring of eight token cells that
// rotate on every tick. Pattern bytes must be loaded before a tick reads them.
// Configuration writes act at once and are meant for idle periods only.
module led_matrix_scroll_scanner_core import lmss_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] load_addr, [13:6] load_data, [14] hold, [15] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] row_bits, [15:8] col_enable_n, [21:16] window_offset, [22] done_res,
  // [23] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [REPS_W-1:0]  frame_repeats_q;
  logic [STEPS_W-1:0] scroll_steps_q;
  logic               scroll_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_repeats_q <= RST_FRAME_REPEATS;
      scroll_steps_q  <= RST_SCROLL_STEPS;
      scroll_mode_q   <= RST_SCROLL_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_REPEATS: frame_repeats_q <= cfg_wdata_i[REPS_W-1:0];
        CFG_SCROLL_STEPS:  scroll_steps_q  <= cfg_wdata_i[STEPS_W-1:0];
        CFG_SCROLL_MODE:   scroll_mode_q   <= cfg_wdata_i[0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic                  in_acc, tick_acc, load_acc;
  logic [LOAD_ADR_W-1:0] in_addr;
  logic [ROW_W-1:0]      in_data;
  logic                  in_hold;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_addr  = s_axis_tdata[LOAD_ADR_W-1:0];
  assign in_data  = s_axis_tdata[LOAD_ADR_W +: ROW_W];
  assign in_hold  = s_axis_tdata[LOAD_ADR_W + ROW_W];
  assign tick_acc = in_acc && (func_e'(s_axis_tuser[0]) == FUNC_TICK);
  assign load_acc = in_acc && (func_e'(s_axis_tuser[0]) == FUNC_LOAD);

  // ---------------------------------------------------------------------------
  // Column token ring: exactly one cell holds the active column
  // ---------------------------------------------------------------------------
  logic [NUM_COLS-1:0] col_token;
  logic [NUM_COLS-1:0] col_n;
  logic [COL_W-1:0]    col_idx;
  logic                last_col;

  for (genvar i = 0; i < NUM_COLS; i++) begin : g_col
    lmss_col_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rst_token_i ((i == 0) ? 1'b1 : 1'b0),
      .shift_i     (tick_acc),
      .token_i     (col_token[(i + NUM_COLS - 1) % NUM_COLS]),
      .token_o     (col_token[i]),
      .col_n_o     (col_n[i])
    );
  end

  always_comb begin
    col_idx = '0;
    for (int i = 0; i < NUM_COLS; i++) begin
      if (col_token[i]) begin
        col_idx = col_idx | COL_W'(i);
      end
    end
  end

  assign last_col = col_token[NUM_COLS-1];

  // ---------------------------------------------------------------------------
  // Scroll animation state, updated at frame end unless held, static or finished
  // ---------------------------------------------------------------------------
  logic [REPS_W-1:0]  repeat_count_q, repeat_count_d, rep_inc, reps;
  logic [OFFS_W-1:0]  offset_q, offset_d;
  logic               finished_q, finished_d;
  logic [STEPS_W-1:0] steps;
  logic [OFFS_W-1:0]  offs;

  // zero in either register behaves as one
  assign reps    = (frame_repeats_q == '0) ? REPS_W'(1) : frame_repeats_q;
  assign steps   = (scroll_steps_q == '0) ? STEPS_W'(1) : scroll_steps_q;
  assign rep_inc = repeat_count_q + 1'b1;
  assign offs    = scroll_mode_q ? offset_q : '0;

  always_comb begin
    repeat_count_d = repeat_count_q;
    offset_d       = offset_q;
    finished_d     = finished_q;
    if (tick_acc && last_col && scroll_mode_q && !finished_q && !in_hold) begin
      if (rep_inc < reps) begin
        repeat_count_d = rep_inc;
      end else begin
        repeat_count_d = '0;
        if (({1'b0, offset_q} + 1'b1) >= {1'b0, steps}) begin
          finished_d = 1'b1;
        end else begin
          offset_d = offset_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_count_q <= '0;
      offset_q       <= '0;
      finished_q     <= 1'b0;
    end else begin
      repeat_count_q <= repeat_count_d;
      offset_q       <= offset_d;
      finished_q     <= finished_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pattern store: loads write, ticks read; read data is registered and reaches the result in the next cycle, no later
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]  rd_sum;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [ROW_W-1:0]  ram_rdata;

  assign rd_sum  = {1'b0, offs} + SUM_W'(col_idx);
  assign rd_addr = MOD_TBL[rd_sum];
  assign wr_addr = MOD_TBL[SUM_W'(in_addr)];

  lmss_ram #(
    .Width (ROW_W),
    .Depth (PATTERN_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (wr_addr),
    .wdata_i (in_data),
    .re_i    (tick_acc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Read stage: result fields that wait for the store data
  // ---------------------------------------------------------------------------
  logic                s1_valid_q;
  logic                s1_tick_q;
  logic [NUM_COLS-1:0] s1_col_n_q;
  logic [OFFS_W-1:0]   s1_offs_q;
  logic                s1_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_tick_q  <= tick_acc;
      s1_col_n_q <= tick_acc ? col_n : '1;
      s1_offs_q  <= offs;
      s1_done_q  <= finished_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue and stream output
  // ---------------------------------------------------------------------------
  res_t                 push_res, head_res;
  logic                 out_pop;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]   in_flight;

  always_comb begin
    push_res.row_bits      = s1_tick_q ? ram_rdata : '0;
    push_res.col_enable_n  = s1_col_n_q;
    push_res.window_offset = s1_offs_q;
    push_res.done_res      = s1_done_q;
  end

  assign out_pop = m_axis_tvalid && m_axis_tready;

  lmss_out_fifo u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_res),
    .pop_i       (out_pop),
    .valid_o     (m_axis_tvalid),
    .data_o      (head_res),
    .count_o     (q_count)
  );

  // room for one more in the queue once everything in flight has landed
  assign in_flight     = {1'b0, q_count} + (OUT_CNT_W + 1)'(s1_valid_q);
  assign s_axis_tready = (in_flight < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, head_res};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(col_token))
    else $error("column token ring lost its single token");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("result queue overcommitted");

  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("finished flag cleared without reset");

  a_static_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scroll_mode_q |=> ($stable(offset_q) && $stable(repeat_count_q)))
    else $error("animation moved in static mode");

  a_accept_reaches_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted transaction missing from read stage");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Bench for the LED matrix column scanner. Every input transaction (load or
// tick) is scored against a behavioural model of the scanner kept in this
// module: pattern store, column position, repeat counter, window offset and
// the finished flag. Each result transaction is compared field by field with
// the oldest pending prediction. Registers are only written with the block
// drained. A scroll run can finish only once per reset, so the phases are
// ordered so that the run end comes last.
module tb_top;
  import lmss_pkg::*;

  // Index past the three registers: writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [COL_W-1:0]     LAST_COL      = 3'd7;
  localparam int unsigned          RUN_LIMIT_NS  = 1_600_000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  led_matrix_scroll_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scanner model state
  logic [ROW_W-1:0]   led_pattern [PATTERN_DEPTH];
  logic [COL_W-1:0]   col_pos      = '0;
  logic [REPS_W-1:0]  frame_cnt    = '0;
  logic [OFFS_W-1:0]  window_pos   = '0;
  logic               run_done     = 1'b0;
  logic [REPS_W-1:0]  frames_per_win = RST_FRAME_REPEATS;
  logic [STEPS_W-1:0] win_count      = RST_SCROLL_STEPS;
  logic               scrolling      = RST_SCROLL_MODE;

  res_t pending_drives [$];

  // Run statistics and knobs
  int unsigned err_cnt     = 0;
  int unsigned n_loads     = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_checked   = 0;
  int unsigned max_offset  = 0;
  int unsigned send_gap_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned stall_left    = 0;

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 2);
    else if (roll < 96) return $urandom_range(3, 6);
    else return $urandom_range(10, 40);
  endfunction

  // Frame boundary: advance the animation unless frozen, held or finished
  function automatic void end_of_frame(input logic hold);
    int unsigned reps;
    int unsigned steps;
    if (!scrolling || run_done || hold) return;
    reps  = (frames_per_win == 0) ? 1 : frames_per_win;
    steps = (win_count == 0) ? 1 : win_count;
    frame_cnt = frame_cnt + 1'b1;
    if (frame_cnt < reps) return;
    frame_cnt = '0;
    if (int'(window_pos) + 1 >= steps) run_done = 1'b1;
    else window_pos = window_pos + 1'b1;
  endfunction

  // Expected drive for one accepted transaction; updates the model state
  function automatic res_t compute_led_drive(input func_e func, input logic [5:0] addr,
                                             input logic [7:0] data, input logic hold);
    res_t r;
    logic [OFFS_W-1:0] offs;
    int unsigned rd_addr;
    offs = scrolling ? window_pos : '0;
    r.window_offset = offs;
    r.done_res      = run_done;
    if (func == FUNC_LOAD) begin
      led_pattern[int'(addr) % PATTERN_DEPTH] = data;
      r.row_bits     = '0;
      r.col_enable_n = '1;
    end else begin
      rd_addr        = (int'(offs) + int'(col_pos)) % PATTERN_DEPTH;
      r.row_bits     = led_pattern[rd_addr];
      r.col_enable_n = ~(8'd1 << col_pos);
      if (col_pos == LAST_COL) end_of_frame(hold);
      col_pos = col_pos + 1'b1;
    end
    return r;
  endfunction

  // One input transaction, with an optional idle gap in front of it.
  // tvalid stays high after acceptance; the next send or drain changes it on a falling edge.
  task automatic send_item(input func_e func, input logic [5:0] addr,
                           input logic [7:0] data, input logic hold);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? idle_span() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, hold, data, addr};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_drives.push_back(compute_led_drive(func, addr, data, hold));
    if (func == FUNC_LOAD) n_loads++;
    else n_ticks++;
  endtask

  task automatic send_random(input int unsigned tick_pct, input int unsigned hold_pct);
    func_e func;
    logic  hold;
    func = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_LOAD;
    hold = ($urandom_range(0, 99) < hold_pct);
    send_item(func, 6'($urandom), 8'($urandom), hold);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_FRAME_REPEATS: frames_per_win = val;
      CFG_SCROLL_STEPS:  win_count      = val[STEPS_W-1:0];
      CFG_SCROLL_MODE:   scrolling      = val[0];
      default: ;
    endcase
  endtask

  // Sink side: random back-pressure on the result stream
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      stall_left = idle_span() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Score each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[RES_W-1:0]);
      if (pending_drives.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_axis_tdata);
      end else begin
        want = pending_drives.pop_front();
        check_field("row_bits", want.row_bits, got.row_bits);
        check_field("col_enable_n", want.col_enable_n, got.col_enable_n);
        check_field("window_offset", want.window_offset, got.window_offset);
        check_field("done_res", want.done_res, got.done_res);
        n_checked++;
        if (got.window_offset > max_offset) max_offset = got.window_offset;
      end
    end
  end

  // Extremes of the fields, a load inside a frame, hold at a frame boundary.
  // Only columns 0..7 are read here, and they are loaded first.
  task automatic test_directed();
    logic [7:0] seed_rows [8];
    seed_rows = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < 8; i++) send_item(FUNC_LOAD, 6'(i), seed_rows[i], 1'b0);
    send_item(FUNC_LOAD, 6'd63, 8'hFF, 1'b1);
    send_item(FUNC_LOAD, 6'd32, 8'h3C, 1'b0);
    for (int c = 0; c < 8; c++) begin
      if (c == 4) send_item(FUNC_LOAD, 6'd8, 8'h81, 1'b0);
      send_item(FUNC_TICK, 6'd63, 8'hFF, (c == 7));
    end
    for (int c = 0; c < 4; c++) send_item(FUNC_TICK, 6'd0, 8'h00, 1'b0);
  endtask

  // Every address written before random ticks start reading the store
  task automatic test_fill_store();
    int unsigned order [PATTERN_DEPTH];
    send_gap_pct   = 20;
    sink_stall_pct = 20;
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i]) send_item(FUNC_LOAD, 6'(order[i]), 8'($urandom), 1'($urandom));
  endtask

  // Static window: offset stays 0 and the counters do not move
  task automatic test_static_mode();
    write_reg(CFG_SCROLL_MODE, 8'd0);
    write_reg(CFG_FRAME_REPEATS, 8'd1);
    write_reg(CFG_SCROLL_STEPS, 8'd0);
    send_gap_pct   = 25;
    sink_stall_pct = 25;
    repeat (100) send_random(75, 20);
    write_reg(CFG_SCROLL_STEPS, 8'd1);
    repeat (100) send_random(75, 20);
  endtask

  // Scrolling with hold dropping frames at random
  task automatic test_scroll_with_hold();
    write_reg(CFG_SCROLL_STEPS, 8'd63);
    write_reg(CFG_FRAME_REPEATS, 8'd2);
    write_reg(CFG_SCROLL_MODE, 8'd1);
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    repeat (150) send_random(80, 30);
    send_gap_pct   = 30;
    sink_stall_pct = 30;
    repeat (250) send_random(75, 30);
  endtask

  // Leaving scroll mode mid-run shows offset 0; the counters pick up again later
  task automatic test_static_resume();
    write_reg(CFG_SCROLL_MODE, 8'd0);
    send_gap_pct   = 15;
    sink_stall_pct = 40;
    repeat (120) send_random(80, 10);
    write_reg(CFG_SCROLL_MODE, 8'd1);
    repeat (60) send_random(80, 10);
  endtask

  // Zero repeats behaves as one, the largest repeat count, the spare index
  task automatic test_repeat_extremes();
    write_reg(CFG_FRAME_REPEATS, 8'd0);
    send_gap_pct   = 40;
    sink_stall_pct = 10;
    repeat (120) send_random(85, 0);
    write_reg(CFG_FRAME_REPEATS, 8'd255);
    repeat (100) send_random(85, 5);
    write_reg(CFG_IDX_SPARE, 8'hFF);
    repeat (40) send_random(85, 5);
    write_reg(CFG_FRAME_REPEATS, 8'd1);
    repeat (60) send_random(85, 5);
  endtask

  // Scroll to the last window (offset 62, store address wrap) and past the end
  task automatic test_scroll_run_end();
    int unsigned guard;
    send_gap_pct   = 20;
    sink_stall_pct = 20;
    guard = 0;
    while (!run_done && guard < 2000) begin
      send_random(85, 10);
      guard++;
    end
    repeat (80) send_random(80, 20);
    // nothing may move once the run has finished
    write_reg(CFG_SCROLL_STEPS, 8'd1);
    write_reg(CFG_FRAME_REPEATS, 8'd7);
    repeat (60) send_random(80, 20);
    write_reg(CFG_SCROLL_MODE, 8'd0);
    repeat (40) send_random(80, 20);
    write_reg(CFG_SCROLL_MODE, 8'd1);
    repeat (40) send_random(80, 20);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_store();
    test_static_mode();
    test_scroll_with_hold();
    test_static_resume();
    test_repeat_extremes();
    test_scroll_run_end();
    drain();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d loads and %0d ticks, %0d results scored.", n_loads, n_ticks, n_checked);
    $display("Window offsets up to %0d seen, scroll run finished: %0d.", max_offset, run_done);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d results outstanding", pending_drives.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lmss_pkg.sv
hdl/lmss_ram.sv
hdl/lmss_col_cell.sv
hdl/lmss_out_fifo.sv
hdl/led_matrix_scroll_scanner_core.sv
bench/tb_top.sv
